### src/attention_decode_online_softmax_top_assert.svh
// assertion macros for the attention decode block
`ifndef ATTENTION_DECODE_ONLINE_SOFTMAX_TOP_ASSERT_SVH
`define ATTENTION_DECODE_ONLINE_SOFTMAX_TOP_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ADOS_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ADOS_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### src/ados_pkg.sv
// shared types, constants and functions for the attention decode block
package ados_pkg;

  localparam int unsigned MaxHeadDim    = 128;
  localparam int unsigned MaxGroupHeads = 8;
  localparam int unsigned DimW   = $clog2(MaxHeadDim);
  localparam int unsigned HeadW  = $clog2(MaxGroupHeads);
  localparam int unsigned StoreW = DimW + HeadW;
  localparam int unsigned AddrW  = 4;

  localparam logic [2:0] KindQuery = 3'd0;
  localparam logic [2:0] KindKey   = 3'd1;
  localparam logic [2:0] KindValue = 3'd2;
  localparam logic [2:0] KindRead  = 3'd3;
  localparam logic [2:0] KindClear = 3'd4;

  localparam logic [AddrW-1:0] RegHeadDim = 4'h0;
  localparam logic [AddrW-1:0] RegHeads   = 4'h4;
  localparam logic [AddrW-1:0] RegGain    = 4'h8;

  localparam logic signed [31:0] MaxFloor = 32'sh8000_0000;
  localparam logic [16:0] OneQ16 = 17'h10000;

  // decoded operation carried through the queue
  typedef enum logic [2:0] {
    OpQuery, OpKey, OpValue, OpRead, OpClear
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [2:0]         head;
    logic [6:0]         dim;
    logic signed [31:0] elem;
    logic               last;
  } cmd_t;

  // 2^(j/256) in unsigned Q1.16
  function automatic logic [16:0] exp_tab(input logic [7:0] j);
    logic [63:0] v;
    logic [16:0] r;
    v = 64'd1 << 30;
    r = '0;
    for (int k = 0; k < 256; k++) begin
      if (k == int'(j)) r = 17'((v + 64'd8192) >> 14);
      v = (v * 64'd1076653033 + (64'd1 << 29)) >> 30;
    end
    return r;
  endfunction

endpackage

### src/ados_front.sv
// front end: decodes items, clamps registers and queues commands
module ados_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [2:0]         head_i,
  input  logic [6:0]         dim_i,
  input  logic signed [31:0] elem_i,
  input  logic [7:0]         head_dim_used_i,
  output ados_pkg::cmd_t     cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i,
  output logic               busy_o
);
  import ados_pkg::*;

  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic [7:0] nd;
  cmd_t       c;
  logic       keep, push;

  always_comb begin
    nd = head_dim_used_i;
    if (nd < 8'd4) nd = 8'd4;
    if (nd > 8'(MaxHeadDim)) nd = 8'(MaxHeadDim);
    c = '0;
    c.head = head_i;
    c.dim = dim_i;
    c.elem = elem_i;
    c.last = ({1'b0, dim_i} == nd - 8'd1);
    keep = 1'b1;
    unique case (kind_i)
      KindQuery: c.op = OpQuery;
      KindKey: begin
        c.op = OpKey;
        keep = {1'b0, dim_i} < nd;
      end
      KindValue: begin
        c.op = OpValue;
        keep = {1'b0, dim_i} < nd;
      end
      KindRead: c.op = OpRead;
      KindClear: c.op = OpClear;
      default: begin
        c.op = OpQuery;
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall_o  = (cnt_q == 2'd2);
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_o       = fifo_q[rp_q];
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign busy_o      = cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (cmd_pop_i) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop_i);
    end
  end
endmodule

### src/ados_back.sv
// back end: sequencer over heads with query and accumulator memories
module ados_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ados_pkg::cmd_t     cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  logic [3:0]         heads_i,
  input  logic [31:0]        gain_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] out_elem_o,
  output logic signed [31:0] running_max_o,
  output logic [47:0]        running_sum_o,
  output logic               busy_o
);
  import ados_pkg::*;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StQMul  = 4'd1;
  localparam logic [3:0] StQWr   = 4'd2;
  localparam logic [3:0] StKRd   = 4'd3;
  localparam logic [3:0] StKMul  = 4'd4;
  localparam logic [3:0] StKAcc  = 4'd5;
  localparam logic [3:0] StFin   = 4'd6;
  localparam logic [3:0] StFin2  = 4'd7;
  localparam logic [3:0] StVRd   = 4'd8;
  localparam logic [3:0] StVMul  = 4'd9;
  localparam logic [3:0] StVAcc  = 4'd10;
  localparam logic [3:0] StRRd   = 4'd11;
  localparam logic [3:0] StClr   = 4'd12;
  localparam logic [3:0] StSum   = 4'd13;
  localparam logic [3:0] StFin3  = 4'd14;

  logic [3:0] st_q;
  cmd_t       cmd_q;
  logic [HeadW-1:0] g_q;
  logic [3:0] nh;

  logic signed [31:0] qmem [MaxGroupHeads*MaxHeadDim];
  logic signed [47:0] amem [MaxGroupHeads*MaxHeadDim];
  logic signed [31:0] qrd_q;
  logic signed [47:0] ard_q;

  logic signed [47:0] sacc_q [MaxGroupHeads];
  logic signed [31:0] hmax_q [MaxGroupHeads];
  logic [47:0]        hsum_q [MaxGroupHeads];
  logic [16:0]        prob_q [MaxGroupHeads];
  logic [16:0]        resc_q [MaxGroupHeads];

  logic signed [65:0] prod_q;
  logic signed [65:0] prod2_q;
  logic [StoreW:0]    clr_q;
  logic signed [31:0] mn_q, s_q;
  logic [16:0]        a_q, p_q;

  logic               ov_q;
  logic signed [47:0] oe_q;
  logic signed [31:0] om_q;
  logic [47:0]        os_q;

  logic [StoreW-1:0] qaddr, raddr, rdaddr;
  assign raddr = {g_q, cmd_q.dim};
  assign qaddr = {cmd_q.head, cmd_q.dim};
  // a read looks up the accumulator with the command being popped
  assign rdaddr = (st_q == StIdle) ? {cmd_i.head, cmd_i.dim} : raddr;

  always_comb begin
    nh = heads_i;
    if (nh < 4'd1) nh = 4'd1;
    if (nh > 4'(MaxGroupHeads)) nh = 4'(MaxGroupHeads);
  end

  function automatic logic signed [47:0] sat48(input logic signed [66:0] v);
    if (v > 67'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (v < -67'sh8000_0000_0000) return 48'sh8000_0000_0000;
    return v[47:0];
  endfunction

  // exp2 of non-positive x
  function automatic logic [16:0] exp2q(input logic signed [32:0] x, input logic [16:0] t,
                                        input logic signed [48:0] y);
    logic signed [32:0] ip;
    logic [32:0] sh;
    ip = 33'(y >>> 16);
    sh = 33'(-ip);
    if (x > 0) return OneQ16;
    if (sh >= 33'd32) return '0;
    return t >> sh[4:0];
  endfunction

  logic signed [48:0] ya, yp;
  logic signed [32:0] xa, xp;
  always_comb begin
    xa = 33'(hmax_q[g_q]) - 33'(mn_q);
    xp = 33'(s_q) - 33'(mn_q);
    ya = 49'((50'(xa) * 50'sd94548) >>> 16);
    yp = 49'((50'(xp) * 50'sd94548) >>> 16);
  end

  logic last_head;
  assign last_head = ({1'b0, g_q} == nh - 4'd1);

  assign cmd_pop_o   = (st_q == StIdle) && cmd_valid_i &&
                       !(cmd_i.op == OpRead && ov_q && out_stall_i);
  assign out_valid_o = ov_q;
  assign out_elem_o = oe_q;
  assign running_max_o = om_q;
  assign running_sum_o = os_q;
  assign busy_o = (st_q != StIdle);

  always_ff @(posedge clk_i) begin
    if (st_q == StQWr) qmem[qaddr] <= (prod_q > 66'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
      (prod_q < -66'sh8000_0000) ? 32'sh8000_0000 : prod_q[31:0];
    if (st_q == StVAcc) amem[raddr] <= sat48(67'(prod_q) + 67'(prod2_q));
    else if (st_q == StClr) amem[clr_q[StoreW-1:0]] <= '0;
    qrd_q <= qmem[raddr];
    ard_q <= amem[rdaddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      clr_q <= '0;
      g_q <= '0;
      ov_q <= 1'b0;
      for (int i = 0; i < MaxGroupHeads; i++) begin
        sacc_q[i] <= '0;
        hmax_q[i] <= MaxFloor;
        hsum_q[i] <= '0;
        prob_q[i] <= '0;
        resc_q[i] <= OneQ16;
      end
    end else begin
      if (st_q == StRRd) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      unique case (st_q)
        StIdle: if (cmd_pop_o) begin
          cmd_q <= cmd_i;
          g_q <= '0;
          unique case (cmd_i.op)
            OpQuery: st_q <= StQMul;
            OpKey:   st_q <= StKRd;
            OpValue: st_q <= StVRd;
            OpRead:  st_q <= StRRd;
            OpClear: begin
              st_q <= StClr;
              clr_q <= '0;
            end
            default: st_q <= StIdle;
          endcase
        end
        StQMul: begin
          prod_q <= 66'((65'(cmd_q.elem) * $signed({1'b0, gain_i})) >>> 16);
          st_q <= StQWr;
        end
        StQWr: st_q <= StIdle;
        StKRd: st_q <= StKMul;
        StKMul: begin
          prod_q <= 66'((64'(qrd_q) * 64'(cmd_q.elem)) >>> 16);
          st_q <= StKAcc;
        end
        StKAcc: begin
          sacc_q[g_q] <= sat48(67'(sacc_q[g_q]) + 67'(prod_q));
          if (last_head) begin
            g_q <= '0;
            st_q <= cmd_q.last ? StFin : StIdle;
          end else begin
            g_q <= g_q + 1'b1;
            st_q <= StKRd;
          end
        end
        StFin: begin
          s_q <= (sacc_q[g_q] > 48'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                 (sacc_q[g_q] < -48'sh8000_0000) ? 32'sh8000_0000 : sacc_q[g_q][31:0];
          st_q <= StFin2;
        end
        StFin2: begin
          mn_q <= (s_q > hmax_q[g_q]) ? s_q : hmax_q[g_q];
          st_q <= StFin3;
        end
        StFin3: begin
          a_q <= exp2q(xa, exp_tab(ya[15:8]), ya);
          p_q <= exp2q(xp, exp_tab(yp[15:8]), yp);
          st_q <= StSum;
        end
        StSum: begin
          logic [64:0] t;
          t = 65'((66'(hsum_q[g_q]) * 66'(a_q)) >> 16) + 65'(p_q);
          hsum_q[g_q] <= (t > 65'h0_FFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : t[47:0];
          hmax_q[g_q] <= mn_q;
          resc_q[g_q] <= a_q;
          prob_q[g_q] <= p_q;
          sacc_q[g_q] <= '0;
          if (last_head) st_q <= StIdle;
          else begin
            g_q <= g_q + 1'b1;
            st_q <= StFin;
          end
        end
        StVRd: st_q <= StVMul;
        StVMul: begin
          prod_q <= 66'((66'(ard_q) * $signed({1'b0, resc_q[g_q]})) >>> 16);
          prod2_q <= 66'($signed({1'b0, prob_q[g_q]}) * cmd_q.elem);
          st_q <= StVAcc;
        end
        StVAcc: begin
          if (last_head) begin
            if (cmd_q.last) begin
              for (int i = 0; i < MaxGroupHeads; i++) begin
                if (i < int'(nh)) begin
                  prob_q[i] <= '0;
                  resc_q[i] <= OneQ16;
                end
              end
            end
            st_q <= StIdle;
          end else begin
            g_q <= g_q + 1'b1;
            st_q <= StVRd;
          end
        end
        StRRd: begin
          oe_q <= ard_q;
          om_q <= hmax_q[cmd_q.head];
          os_q <= hsum_q[cmd_q.head];
          st_q <= StIdle;
        end
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q[StoreW-1:0] == '1) st_q <= StIdle;
          for (int i = 0; i < MaxGroupHeads; i++) begin
            sacc_q[i] <= '0;
            hmax_q[i] <= MaxFloor;
            hsum_q[i] <= '0;
            prob_q[i] <= '0;
            resc_q[i] <= OneQ16;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end
endmodule

### src/attention_decode_online_softmax_top.sv
// top level of the attention decode online softmax block
// Grouped-query decode attention over one split with a fixed-point online
// softmax. Items enter a front end that decodes them into a two-entry command
// queue; a back-end sequencer walks the group's heads one at a time. A query
// item passes the multiply and write states; a key item and a value item each
// pass a read, a multiply and an accumulate state per head; the last key
// element adds saturate, max, exp and sum states per head; a read passes the
// read state and a clear split sweeps the 1024-entry accumulator memory.
// After reset the same clearing pass runs before items are taken from the
// queue. Reads of the query memory are registered.
module attention_decode_online_softmax_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         kind_i,
  input  logic [2:0]         head_i,
  input  logic [6:0]         dim_i,
  input  logic signed [31:0] elem_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] out_elem_o,
  output logic signed [31:0] running_max_o,
  output logic [47:0]        running_sum_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ados_pkg::AddrW-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ados_pkg::*;

  logic [7:0]  hdim_q;
  logic [3:0]  heads_q;
  logic [31:0] gain_q;
  cmd_t        cmd;
  logic        cmd_valid, cmd_pop, fbusy, bbusy;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdim_q <= 8'd128;
      heads_q <= 4'd8;
      gain_q <= 32'h10000;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        RegHeadDim: hdim_q <= pwdata[7:0];
        RegHeads:   heads_q <= pwdata[3:0];
        RegGain:    gain_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      RegHeadDim: prdata = {24'd0, hdim_q};
      RegHeads:   prdata = {28'd0, heads_q};
      RegGain:    prdata = gain_q;
      default:    prdata = '0;
    endcase
  end

  ados_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .head_i, .dim_i, .elem_i,
    .head_dim_used_i(hdim_q), .cmd_o(cmd), .cmd_valid_o(cmd_valid),
    .cmd_pop_i(cmd_pop), .busy_o(fbusy)
  );

  ados_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop),
    .heads_i(heads_q), .gain_i(gain_q), .out_valid_o, .out_stall_i, .out_elem_o,
    .running_max_o, .running_sum_o, .busy_o(bbusy)
  );

  logic unused_busy;
  assign unused_busy = fbusy & bbusy;
endmodule

### src/ados_checker.sv
// port-level checker for the attention decode block, bound to the top level
`include "attention_decode_online_softmax_top_assert.svh"
module ados_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [47:0] out_elem_o,
  input logic [47:0] running_sum_o,
  input logic [31:0] running_max_o,
  input logic        pready
);
  `ADOS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(running_sum_o), "result dropped while stalled")
  `ADOS_ASSERT_NEXT(a_max_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(running_max_o), "running max changed while stalled")
  `ADOS_ASSERT_NEXT(a_elem_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    $stable(out_elem_o), "output element changed while stalled")
  `ADOS_ASSERT_IMPL(a_ready, clk_i, rst_ni, 1'b1, pready, "pready low")
endmodule

bind attention_decode_online_softmax_top ados_checker u_chk (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .out_elem_o,
  .running_sum_o, .running_max_o, .pready
);

### sim/attention_decode_online_softmax_top_test.sv
// self-checking testbench for the attention decode online softmax block
module attention_decode_online_softmax_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ados_pkg::*;

  localparam int unsigned  ClockHalf    = 6;
  localparam int unsigned  IdleLimit    = 8000;
  localparam int unsigned  DrainCycles  = 1300;  // a clear split sweeps 1024 entries
  localparam int unsigned  HoldCycles   = 400;
  localparam logic [2:0]   KindSpareLo  = 3'd5;
  localparam logic [2:0]   KindSpareHi  = 3'd7;
  localparam longint       Log2eQ16     = 94548;
  localparam longint       RootQ30      = 64'd1076653033;
  localparam longint       Sat48Hi      = 64'sd140737488355327;
  localparam longint       Sat48Lo      = -64'sd140737488355328;
  localparam longint unsigned SumCeil   = 64'd281474976710655;
  localparam int           StoreDepth   = MaxGroupHeads * MaxHeadDim;

  // predicted attention state plus the reads still owed by the block
  class softmax_scoreboard;
    typedef struct {
      logic [47:0] acc;
      logic [31:0] maxv;
      logic [47:0] sumv;
    } read_t;

    read_t          owed_reads[$];
    int             errors;
    int unsigned    pow_tab[256];
    logic [7:0]     cfg_dim;
    logic [3:0]     cfg_heads;
    logic [31:0]    cfg_gain;
    int             query_mem[StoreDepth];
    longint         acc_mem[StoreDepth];
    longint         score[8];
    int             hmax[8];
    longint unsigned hsum[8];
    int unsigned    prob[8];
    int unsigned    resc[8];

    function new();
      longint unsigned v;
      v = 64'd1 << 30;
      for (int j = 0; j < 256; j++) begin
        pow_tab[j] = int'((v + 64'd8192) >> 14);
        v = (v * RootQ30 + (64'd1 << 29)) >> 30;
      end
      errors = 0;
      cfg_dim = 8'd128;
      cfg_heads = 4'd8;
      cfg_gain = 32'd65536;
      foreach (query_mem[i]) query_mem[i] = 0;
      clear_split();
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void clear_split();
      foreach (acc_mem[i]) acc_mem[i] = 0;
      for (int g = 0; g < 8; g++) begin
        score[g] = 0;
        hmax[g] = int'(MaxFloor);
        hsum[g] = 0;
        prob[g] = 0;
        resc[g] = 65536;
      end
    endfunction

    function int row_len();
      if (cfg_dim < 4) return 4;
      if (cfg_dim > MaxHeadDim) return MaxHeadDim;
      return int'(cfg_dim);
    endfunction

    function int group_len();
      if (cfg_heads < 1) return 1;
      if (cfg_heads > MaxGroupHeads) return MaxGroupHeads;
      return int'(cfg_heads);
    endfunction

    function longint sat(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    // 2^(x*log2e) for x <= 0: table on the fraction, shift on the integer part
    function int unsigned pow2_neg(longint x);
      longint y;
      longint ip;
      longint sh;
      int     f;
      if (x > 0) x = 0;
      y = (x * Log2eQ16) >>> 16;
      ip = y >>> 16;
      f = int'(y - ip * 65536);
      sh = -ip;
      if (sh >= 32) return 0;
      return pow_tab[(f >> 8) & 255] >> sh;
    endfunction

    function void close_key_row(int nh);
      int s;
      int mn;
      int unsigned a;
      int unsigned p;
      longint unsigned total;
      for (int g = 0; g < nh; g++) begin
        s = int'(sat(score[g], -64'sd2147483648, 64'sd2147483647));
        mn = s > hmax[g] ? s : hmax[g];
        a = pow2_neg(longint'(hmax[g]) - longint'(mn));
        p = pow2_neg(longint'(s) - longint'(mn));
        total = ((hsum[g] * longint'(a)) >> 16) + longint'(p);
        hsum[g] = total > SumCeil ? SumCeil : total;
        hmax[g] = mn;
        resc[g] = a;
        prob[g] = p;
        score[g] = 0;
      end
    endfunction

    function void note_input(logic [2:0] kind, logic [2:0] head, logic [6:0] dim,
                             logic signed [31:0] elem);
      int     nd;
      int     nh;
      int     ix;
      longint v;
      read_t  r;
      nd = row_len();
      nh = group_len();
      case (kind)
        KindQuery: begin
          v = (longint'(elem) * longint'({32'b0, cfg_gain})) >>> 16;
          query_mem[head * MaxHeadDim + dim] = int'(sat(v, -64'sd2147483648, 64'sd2147483647));
        end
        KindKey: begin
          if (dim < nd) begin
            for (int g = 0; g < nh; g++) begin
              v = score[g] + ((longint'(query_mem[g * MaxHeadDim + dim]) * longint'(elem)) >>> 16);
              score[g] = sat(v, Sat48Lo, Sat48Hi);
            end
            if (dim == nd - 1) close_key_row(nh);
          end
        end
        KindValue: begin
          if (dim < nd) begin
            for (int g = 0; g < nh; g++) begin
              ix = g * MaxHeadDim + dim;
              v = ((acc_mem[ix] * longint'(resc[g])) >>> 16) + longint'(prob[g]) * longint'(elem);
              acc_mem[ix] = sat(v, Sat48Lo, Sat48Hi);
            end
            if (dim == nd - 1) begin
              for (int g = 0; g < nh; g++) begin
                prob[g] = 0;
                resc[g] = 65536;
              end
            end
          end
        end
        KindRead: begin
          r.acc = acc_mem[head * MaxHeadDim + dim][47:0];
          r.maxv = hmax[head];
          r.sumv = hsum[head][47:0];
          owed_reads.push_back(r);
        end
        KindClear: clear_split();
        default: ;
      endcase
    endfunction

    function void check_result(logic [47:0] acc, logic [31:0] maxv, logic [47:0] sumv);
      read_t r;
      if (owed_reads.size() == 0) begin
        report("result with no read outstanding");
        return;
      end
      r = owed_reads.pop_front();
      if (acc !== r.acc) report($sformatf("out_elem %h, predicted %h", acc, r.acc));
      if (maxv !== r.maxv) report($sformatf("running_max %h, predicted %h", maxv, r.maxv));
      if (sumv !== r.sumv) report($sformatf("running_sum %h, predicted %h", sumv, r.sumv));
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         kind_i = '0;
  logic [2:0]         head_i = '0;
  logic [6:0]         dim_i = '0;
  logic signed [31:0] elem_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [47:0] out_elem_o;
  logic signed [31:0] running_max_o;
  logic [47:0]        running_sum_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [AddrW-1:0]   paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  softmax_scoreboard attn_sb = new();
  bit   query_seen[StoreDepth];   // query entries written since reset
  int   counted_items;
  bit   sender_quiet;             // stretches with no gaps on the input side
  bit   hold_req;                 // asks the receiver for its long hold-off
  int   idle_cycles;

  attention_decode_online_softmax_top u_top (.*);

  always #(ClockHalf) clk_i = ~clk_i;

  // watchdog: cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("attention_decode_online_softmax_top_test: errors");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  // receiver: check what was taken at this edge, then pick the next stall
  initial begin : receiver
    int stall_left;
    int hold_left;
    bit hold_done;
    bit quiet;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    quiet = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        attn_sb.check_result(out_elem_o, running_max_o, running_sum_o);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if ($urandom_range(0, 199) == 0) quiet = !quiet;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        // mostly single-cycle stalls, now and then a long one
        if ($urandom_range(0, 99) < 3) stall_left = $urandom_range(15, 80);
        out_stall_i <= ($urandom_range(0, 99) < 30);
      end
    end
  end

  task automatic write_reg(input logic [AddrW-1:0] addr, input logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // offer one item after a random gap and hold it until it is taken
  task automatic send_item(input logic [2:0] kind, input logic [2:0] head,
                           input logic [6:0] dim, input logic signed [31:0] elem);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (sender_quiet || r < 55) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 70);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    head_i <= head;
    dim_i <= dim;
    elem_i <= elem;
    do @(posedge clk_i); while (in_stall_o);
    attn_sb.note_input(kind, head, dim, elem);
    if (kind <= KindClear) counted_items++;
    if ($urandom_range(0, 119) == 0) sender_quiet = !sender_quiet;
  endtask

  function automatic logic [31:0] pick_elem();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return $urandom();
    if (r < 14) return 32'h7FFF_FFFF;
    if (r < 16) return 32'h8000_0000;
    if (r < 18) return 32'h0;
    return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);  // about +-2.0
  endfunction

  // every query entry the group reads must be written before any key row
  task automatic fill_queries();
    int nd;
    int nh;
    nd = attn_sb.row_len();
    nh = attn_sb.group_len();
    for (int g = 0; g < nh; g++)
      for (int d = 0; d < nd; d++)
        if (!query_seen[g * MaxHeadDim + d]) begin
          send_item(KindQuery, 3'(g), 7'(d), pick_elem());
          query_seen[g * MaxHeadDim + d] = 1'b1;
        end
  endtask

  task automatic send_key_row(input bit shuffled);
    int order[$];
    for (int d = 0; d < attn_sb.row_len(); d++) order.push_back(d);
    if (shuffled) order.shuffle();
    foreach (order[i]) send_item(KindKey, 3'($urandom()), 7'(order[i]), pick_elem());
  endtask

  task automatic send_value_row();
    for (int d = 0; d < attn_sb.row_len(); d++)
      send_item(KindValue, 3'($urandom()), 7'(d), pick_elem());
  endtask

  task automatic send_read();
    logic [6:0] d;
    if ($urandom_range(0, 3) == 0) d = 7'($urandom());
    else d = 7'($urandom_range(0, attn_sb.row_len() - 1));
    send_item(KindRead, 3'($urandom()), d, $urandom());
  endtask

  // short directed opening with a 4-element row and two heads
  task automatic directed_items();
    send_item(KindRead, 3'd0, 7'd0, 32'h0);          // no token yet
    send_item(KindRead, 3'd7, 7'd127, 32'hFFFF_FFFF);
    send_item(KindSpareLo, 3'd7, 7'd127, 32'h8000_0000);
    send_item(KindSpareHi, 3'd0, 7'd0, 32'h7FFF_FFFF);
    send_item(KindKey, 3'd0, 7'd100, 32'h7FFF_FFFF);  // past the row
    send_item(KindQuery, 3'd7, 7'd127, 32'h7FFF_FFFF);
    send_item(KindQuery, 3'd0, 7'd0, 32'h8000_0000);
    send_key_row(1'b0);
    send_value_row();
    send_value_row();                                 // repeated value row adds nothing
    send_key_row(1'b1);                               // token with its value row missing
    send_item(KindRead, 3'd1, 7'd3, 32'h0);
    send_item(KindRead, 3'd0, 7'd0, 32'h0);
    send_item(KindClear, 3'd5, 7'd42, 32'h0);
    send_item(KindRead, 3'd1, 7'd2, 32'h0);
  endtask

  task automatic random_items(input int budget);
    int start;
    int r;
    int nd;
    start = counted_items;
    nd = attn_sb.row_len();
    while (counted_items - start < budget) begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        send_key_row($urandom_range(0, 99) < 30);
        if ($urandom_range(0, 99) < 85) send_value_row();
      end else if (r < 74) begin
        repeat ($urandom_range(1, 4)) send_read();
      end else if (r < 80) begin
        // reload a query entry anywhere in the store
        begin
          logic [2:0] h;
          logic [6:0] d;
          h = 3'($urandom());
          d = 7'($urandom());
          send_item(KindQuery, h, d, pick_elem());
          query_seen[h * MaxHeadDim + d] = 1'b1;
        end
      end else if (r < 86) begin
        send_item(3'($urandom_range(KindSpareLo, KindSpareHi)), 3'($urandom()),
                  7'($urandom()), $urandom());
      end else if (r < 91 && nd < MaxHeadDim) begin
        send_item(3'($urandom_range(KindKey, KindValue)), 3'($urandom()),
                  7'($urandom_range(nd, MaxHeadDim - 1)), $urandom());
      end else if (r < 95) begin
        // broken row: a few keys or values that stop short
        repeat ($urandom_range(1, 3))
          send_item(3'($urandom_range(KindKey, KindValue)), 3'($urandom()),
                    7'($urandom_range(0, nd - 2)), pick_elem());
      end else if (r < 97) begin
        send_item(KindClear, 3'($urandom()), 7'($urandom()), $urandom());
      end else begin
        send_value_row();
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (attn_sb.owed_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  dims[6]  = '{8'd4, 8'd0, 8'd255, 8'd6, 8'd128, 8'd9};
    logic [3:0]  heads[6] = '{4'd2, 4'd15, 4'd3, 4'd0, 4'd1, 4'd8};
    logic [31:0] gain;
    counted_items = 0;
    sender_quiet = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      case (p)
        0: gain = 32'd65536;
        1: gain = 32'hFFFF_FFFF;
        2: gain = 32'd0;
        default: gain = $urandom_range(0, 3 * 65536);
      endcase
      write_reg(RegHeadDim, {24'b0, dims[p]});
      write_reg(RegHeads, {28'b0, heads[p]});
      write_reg(RegGain, gain);
      attn_sb.cfg_dim = dims[p];
      attn_sb.cfg_heads = heads[p];
      attn_sb.cfg_gain = gain;
      fill_queries();
      if (p == 0) directed_items();
      if (p == 3) begin
        // long receiver hold-off while reads keep arriving
        hold_req = 1'b1;
        repeat (30) send_read();
      end
      random_items(attn_sb.row_len() >= 64 ? 250 : 100);
    end
    wait_drained();
    if (attn_sb.owed_reads.size() != 0)
      attn_sb.report($sformatf("%0d reads never returned", attn_sb.owed_reads.size()));
    if (attn_sb.errors == 0) begin
      $display("attention_decode_online_softmax_top_test: clean");
    end else begin
      $display("attention_decode_online_softmax_top_test: errors");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/ados_pkg.sv
src/ados_front.sv
src/ados_back.sv
src/attention_decode_online_softmax_top.sv
src/ados_checker.sv
sim/attention_decode_online_softmax_top_test.sv
